// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is held
`define UWLR_ASSERT(name, prop, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Clocked check that also runs through reset
`define UWLR_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

// ===== sv/uwlr_pkg.sv =====
`default_nettype none

package uwlr_pkg;

    // Trigger pulse shape and counter width defaults
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 10;
    localparam int COUNT_BITS      = 16;
    localparam int PULSE_W         = 4;

    // Configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DEPTH     = 3'd0,
        CFG_SENSOR_HEIGHT = 3'd1,
        CFG_ECHO_TIMEOUT  = 3'd2,
        CFG_MAX_WIDTH     = 3'd3,
        CFG_MIN_DISTANCE  = 3'd4,
        CFG_MAX_DISTANCE  = 3'd5
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_MAX_DEPTH     = 16'd15000;
    localparam logic [CFG_W-1:0] RST_SENSOR_HEIGHT = 16'd15000;
    localparam logic [CFG_W-1:0] RST_ECHO_TIMEOUT  = 16'd40000;
    localparam logic [CFG_W-1:0] RST_MAX_WIDTH     = 16'd35000;
    localparam logic [CFG_W-1:0] RST_MIN_DISTANCE  = 16'd200;
    localparam logic [CFG_W-1:0] RST_MAX_DISTANCE  = 16'd40000;

    typedef struct packed {
        logic [CFG_W-1:0] max_depth;
        logic [CFG_W-1:0] sensor_height;
        logic [CFG_W-1:0] echo_timeout;
        logic [CFG_W-1:0] max_width;
        logic [CFG_W-1:0] min_distance;
        logic [CFG_W-1:0] max_distance;
    } t_cfg;

    // Distance scaling: 1.715 hundredths of a cm per tick in Q16
    localparam int               DIST_SCALE_W = 17;
    localparam logic [DIST_SCALE_W-1:0] DIST_SCALE = 17'd112394;
    localparam int               DIST_SHIFT   = 16;
    localparam logic [CFG_W-1:0] HELD_RESET   = 16'd10000;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_TLOW  = 3'd1,
        PH_THIGH = 3'd2,
        PH_RISE  = 3'd3,
        PH_FALL  = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_RANGE   = 2'd2
    } t_status;

    // Per-tick classification handed from front to back
    typedef struct packed {
        logic trig;
        logic busy;
        logic done;
        logic timeout;
        logic finish;
    } t_cmd;

endpackage

`default_nettype wire

// ===== sv/uwlr_tick_if.sv =====
`default_nettype none

// Input channel: one beat per microsecond tick
interface uwlr_tick_if;
    logic valid;
    logic ready;
    logic start_req;
    logic echo;

    modport source (output valid, output start_req, output echo, input ready);
    modport sink   (input valid, input start_req, input echo, output ready);
endinterface

`default_nettype wire

// ===== sv/uwlr_result_if.sv =====
`default_nettype none

// Output channel: one beat per accepted tick
interface uwlr_result_if;
    logic       valid;
    logic       ready;
    logic       trig;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [15:0] water_level;

    modport source (output valid, output trig, output busy_res, output done_res,
                    output status, output water_level, input ready);
    modport sink   (input valid, input trig, input busy_res, input done_res,
                    input status, input water_level, output ready);
endinterface

`default_nettype wire

// ===== sv/uwlr_front.sv =====
`default_nettype none

// Front: trigger sequencer and echo timing, one tick per cycle while the queue has room
module uwlr_front #(
    parameter int TRIG_LOW_TICKS  = uwlr_pkg::TRIG_LOW_TICKS,
    parameter int TRIG_HIGH_TICKS = uwlr_pkg::TRIG_HIGH_TICKS,
    parameter int COUNT_BITS      = uwlr_pkg::COUNT_BITS
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    uwlr_tick_if.sink                    i_tick,
    input  wire [uwlr_pkg::CFG_W-1:0]    i_echo_timeout,
    input  wire                          i_full,
    output logic                         o_push,
    output uwlr_pkg::t_cmd               o_cmd,
    output logic [COUNT_BITS-1:0]        o_width
);

    localparam int PW = uwlr_pkg::PULSE_W;
    localparam logic [PW-1:0] LOW_CNT  = PW'(TRIG_LOW_TICKS);
    localparam logic [PW-1:0] HIGH_CNT = PW'(TRIG_HIGH_TICKS);
    localparam logic          LOW_ONE  = (TRIG_LOW_TICKS <= 1);

    uwlr_pkg::t_phase        r_phase, n_phase;
    logic [PW-1:0]           r_pulse, n_pulse;
    logic [COUNT_BITS-1:0]   r_deadline, n_deadline;
    logic [COUNT_BITS-1:0]   r_width, n_width;
    logic [PW-1:0]           w_pulse_inc;
    logic [COUNT_BITS-1:0]   w_dl_inc, w_wd_inc;
    logic                    w_late;
    logic                    w_accept;

    // Take a tick whenever the queue has room
    assign i_tick.ready = !i_full;
    assign w_accept     = i_tick.valid && !i_full;
    assign o_push       = w_accept;

    // Counters: pulse wraps at four bits, the others saturate
    assign w_pulse_inc = r_pulse + PW'(1);
    assign w_dl_inc    = (&r_deadline) ? r_deadline : r_deadline + COUNT_BITS'(1);
    assign w_wd_inc    = (&r_width) ? r_width : r_width + COUNT_BITS'(1);
    assign w_late      = r_deadline >= COUNT_BITS'(i_echo_timeout);
    assign o_width     = n_width;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= uwlr_pkg::PH_IDLE;
            r_pulse    <= '0;
            r_deadline <= '0;
            r_width    <= '0;
        end else if (w_accept) begin
            r_phase    <= n_phase;
            r_pulse    <= n_pulse;
            r_deadline <= n_deadline;
            r_width    <= n_width;
        end
    end

    // Next state and tick classification
    always_comb begin
        n_phase    = r_phase;
        n_pulse    = r_pulse;
        n_deadline = r_deadline;
        n_width    = r_width;
        o_cmd      = '0;
        case (r_phase)
            uwlr_pkg::PH_IDLE: begin
                if (i_tick.start_req) begin
                    o_cmd.busy = 1'b1;
                    if (LOW_ONE) begin
                        n_phase = uwlr_pkg::PH_THIGH;
                        n_pulse = '0;
                    end else begin
                        n_phase = uwlr_pkg::PH_TLOW;
                        n_pulse = PW'(1);
                    end
                end
            end
            uwlr_pkg::PH_TLOW: begin
                o_cmd.busy = 1'b1;
                n_pulse    = w_pulse_inc;
                if (w_pulse_inc >= LOW_CNT) begin
                    n_phase = uwlr_pkg::PH_THIGH;
                    n_pulse = '0;
                end
            end
            uwlr_pkg::PH_THIGH: begin
                o_cmd.busy = 1'b1;
                o_cmd.trig = 1'b1;
                n_pulse    = w_pulse_inc;
                if (w_pulse_inc >= HIGH_CNT) begin
                    n_phase    = uwlr_pkg::PH_RISE;
                    n_pulse    = '0;
                    n_deadline = '0;
                end
            end
            uwlr_pkg::PH_RISE: begin
                if (w_late) begin
                    o_cmd.done    = 1'b1;
                    o_cmd.timeout = 1'b1;
                    n_phase       = uwlr_pkg::PH_IDLE;
                end else begin
                    o_cmd.busy = 1'b1;
                    if (i_tick.echo) begin
                        n_width = '0;
                        n_phase = uwlr_pkg::PH_FALL;
                    end
                    n_deadline = w_dl_inc;
                end
            end
            uwlr_pkg::PH_FALL: begin
                if (w_late) begin
                    o_cmd.done    = 1'b1;
                    o_cmd.timeout = 1'b1;
                    n_phase       = uwlr_pkg::PH_IDLE;
                end else begin
                    n_width    = w_wd_inc;
                    n_deadline = w_dl_inc;
                    if (!i_tick.echo) begin
                        o_cmd.finish = 1'b1;
                        o_cmd.done   = 1'b1;
                        n_phase      = uwlr_pkg::PH_IDLE;
                    end else begin
                        o_cmd.busy = 1'b1;
                    end
                end
            end
            default: begin
                n_phase = uwlr_pkg::PH_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/uwlr_queue.sv =====
`default_nettype none

// Small flip-flop FIFO between front and back
module uwlr_queue #(
    parameter int DEPTH = uwlr_pkg::QUEUE_DEPTH,
    parameter int WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_full,
    input  wire              i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push, w_pop;

    assign o_full  = r_cnt == CNT_W'(DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PTR_W'(1);
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== sv/uwlr_back.sv =====
`default_nettype none

// Back: distance multiply, window filter, level clamp, output register
module uwlr_back #(
    parameter int COUNT_BITS = uwlr_pkg::COUNT_BITS
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_valid,
    input  wire uwlr_pkg::t_cmd         i_cmd,
    input  wire [COUNT_BITS-1:0]        i_width,
    output logic                        o_pop,
    input  wire uwlr_pkg::t_cfg         i_cfg,
    uwlr_result_if.source               o_result
);

    localparam int CW     = uwlr_pkg::CFG_W;
    localparam int PROD_W = COUNT_BITS + uwlr_pkg::DIST_SCALE_W;
    localparam int DIST_W = PROD_W - uwlr_pkg::DIST_SHIFT;

    // Multiply stage
    logic                  r_m_valid;
    uwlr_pkg::t_cmd        r_m_cmd;
    logic [COUNT_BITS-1:0] r_m_width;
    logic [PROD_W-1:0]     r_m_prod;

    // Output stage
    logic                  r_o_valid;
    logic                  r_o_trig, r_o_busy, r_o_done;
    logic [1:0]            r_o_status;
    logic [CW-1:0]         r_o_level;

    logic [CW-1:0]         r_held, n_held;
    logic                  w_o_ready, w_m_ready, w_m_move;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_bad_width, w_in_window, w_good;
    logic [CW:0]           w_diff;
    logic [CW-1:0]         w_level;
    uwlr_pkg::t_status     w_status;

    // Stage handshakes
    assign w_o_ready = !r_o_valid || o_result.ready;
    assign w_m_ready = !r_m_valid || w_o_ready;
    assign o_pop     = i_valid && w_m_ready;
    assign w_m_move  = r_m_valid && w_o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_m_ready) begin
            r_m_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_cmd   <= i_cmd;
            r_m_width <= i_width;
            r_m_prod  <= PROD_W'(i_width) * PROD_W'(uwlr_pkg::DIST_SCALE);
        end
    end

    // Range check and distance window
    assign w_dist      = r_m_prod[PROD_W-1:uwlr_pkg::DIST_SHIFT];
    assign w_bad_width = (r_m_width == '0) ||
                         (r_m_width > COUNT_BITS'(i_cfg.max_width));
    assign w_good      = r_m_cmd.finish && !w_bad_width;
    assign w_in_window = (w_dist > DIST_W'(i_cfg.min_distance)) &&
                         (w_dist < DIST_W'(i_cfg.max_distance));
    assign n_held      = (w_good && w_in_window) ? w_dist[CW-1:0] : r_held;

    // Level = height - held distance, clamped to 0..max_depth
    assign w_diff = {1'b0, i_cfg.sensor_height} - {1'b0, n_held};
    always_comb begin
        if (w_diff[CW]) begin
            w_level = '0;
        end else if (w_diff[CW-1:0] > i_cfg.max_depth) begin
            w_level = i_cfg.max_depth;
        end else begin
            w_level = w_diff[CW-1:0];
        end
    end

    always_comb begin
        if (r_m_cmd.timeout) begin
            w_status = uwlr_pkg::ST_TIMEOUT;
        end else if (r_m_cmd.finish && w_bad_width) begin
            w_status = uwlr_pkg::ST_RANGE;
        end else begin
            w_status = uwlr_pkg::ST_OK;
        end
    end

    // Held distance and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held    <= uwlr_pkg::HELD_RESET;
            r_o_valid <= 1'b0;
        end else begin
            if (w_m_move) begin
                r_held <= n_held;
            end
            if (w_o_ready) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (w_m_move) begin
            r_o_trig   <= r_m_cmd.trig;
            r_o_busy   <= r_m_cmd.busy;
            r_o_done   <= r_m_cmd.done;
            r_o_status <= w_status;
            r_o_level  <= w_good ? w_level : '0;
        end
    end

    assign o_result.valid       = r_o_valid;
    assign o_result.trig        = r_o_trig;
    assign o_result.busy_res    = r_o_busy;
    assign o_result.done_res    = r_o_done;
    assign o_result.status      = r_o_status;
    assign o_result.water_level = r_o_level;

endmodule

`default_nettype wire

// ===== sv/ultrasonic_water_level_ranger.sv =====
`default_nettype none

// Ultrasonic echo ranger for a water level gauge. Each input beat is one
// microsecond tick carrying a start request and the sampled echo pin; each
// tick gives exactly one result beat with the trigger drive level, busy,
// done, status (ok, echo timeout, width out of range) and the clamped water
// level in hundredths of a cm. A new tick is taken every cycle while the queue
// has room; each tick passes through the queue storage, the distance multiply
// stage and the output register, and a stalled output backs up through a
// four-entry queue before ticks are refused. Configuration writes go to the
// six 16-bit registers at indexes 0..5 and should be made while the block is
// idle; other indexes are ignored.
module ultrasonic_water_level_ranger #(
    parameter int TRIG_LOW_TICKS  = uwlr_pkg::TRIG_LOW_TICKS,
    parameter int TRIG_HIGH_TICKS = uwlr_pkg::TRIG_HIGH_TICKS,
    parameter int COUNT_BITS      = uwlr_pkg::COUNT_BITS
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    uwlr_tick_if.sink                        i_tick,
    uwlr_result_if.source                    o_result,
    input  wire                              i_cfg_we,
    input  wire [uwlr_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [uwlr_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int CMD_W = $bits(uwlr_pkg::t_cmd);
    localparam int Q_W   = CMD_W + COUNT_BITS;

    uwlr_pkg::t_cfg        r_cfg;
    uwlr_pkg::t_cmd        w_f_cmd, w_b_cmd;
    logic [COUNT_BITS-1:0] w_f_width, w_b_width;
    logic                  w_push, w_full, w_q_valid, w_pop;
    logic [Q_W-1:0]        w_q_in, w_q_out;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_depth     <= uwlr_pkg::RST_MAX_DEPTH;
            r_cfg.sensor_height <= uwlr_pkg::RST_SENSOR_HEIGHT;
            r_cfg.echo_timeout  <= uwlr_pkg::RST_ECHO_TIMEOUT;
            r_cfg.max_width     <= uwlr_pkg::RST_MAX_WIDTH;
            r_cfg.min_distance  <= uwlr_pkg::RST_MIN_DISTANCE;
            r_cfg.max_distance  <= uwlr_pkg::RST_MAX_DISTANCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                uwlr_pkg::CFG_MAX_DEPTH:     r_cfg.max_depth     <= i_cfg_data;
                uwlr_pkg::CFG_SENSOR_HEIGHT: r_cfg.sensor_height <= i_cfg_data;
                uwlr_pkg::CFG_ECHO_TIMEOUT:  r_cfg.echo_timeout  <= i_cfg_data;
                uwlr_pkg::CFG_MAX_WIDTH:     r_cfg.max_width     <= i_cfg_data;
                uwlr_pkg::CFG_MIN_DISTANCE:  r_cfg.min_distance  <= i_cfg_data;
                uwlr_pkg::CFG_MAX_DISTANCE:  r_cfg.max_distance  <= i_cfg_data;
                default:                     r_cfg <= r_cfg;
            endcase
        end
    end

    uwlr_front #(
        .TRIG_LOW_TICKS  (TRIG_LOW_TICKS),
        .TRIG_HIGH_TICKS (TRIG_HIGH_TICKS),
        .COUNT_BITS      (COUNT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_tick         (i_tick),
        .i_echo_timeout (r_cfg.echo_timeout),
        .i_full         (w_full),
        .o_push         (w_push),
        .o_cmd          (w_f_cmd),
        .o_width        (w_f_width)
    );

    assign w_q_in = {w_f_cmd, w_f_width};

    uwlr_queue #(
        .DEPTH (uwlr_pkg::QUEUE_DEPTH),
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    assign w_b_cmd   = uwlr_pkg::t_cmd'(w_q_out[Q_W-1:COUNT_BITS]);
    assign w_b_width = w_q_out[COUNT_BITS-1:0];

    uwlr_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_cmd    (w_b_cmd),
        .i_width  (w_b_width),
        .o_pop    (w_pop),
        .i_cfg    (r_cfg),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

// ===== sv/uwlr_checker.sv =====
`default_nettype none

`include "assert_macros.svh"

// Port-level checks on the result channel
module uwlr_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        i_ready,
    input wire        i_trig,
    input wire        i_busy,
    input wire        i_done,
    input wire [1:0]  i_status,
    input wire [15:0] i_level
);

    // Trigger is only driven inside a measurement
    `UWLR_ASSERT(a_trig_busy, i_valid && i_trig |-> i_busy, "trig without busy")

    // The finishing tick is no longer busy
    `UWLR_ASSERT(a_done_idle, i_valid && i_done |-> !i_busy, "done while busy")

    // Status and level are only nonzero on a done beat, and never both at once
    `UWLR_ASSERT(a_fields_clean, i_valid && (i_status != 2'd0 || i_level != 16'd0) |-> i_done && (i_level == 16'd0 || i_status == 2'd0), "stray status or level")

    // Stalled beat holds
    `UWLR_ASSERT(a_stall_hold, i_valid && !i_ready |=> i_valid && $stable({i_trig, i_busy, i_done, i_status, i_level}), "stalled beat changed")

    // Nothing comes out right after reset
    `UWLR_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !i_valid, "valid after reset")

endmodule

bind ultrasonic_water_level_ranger uwlr_checker u_uwlr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_result.valid),
    .i_ready  (o_result.ready),
    .i_trig   (o_result.trig),
    .i_busy   (o_result.busy_res),
    .i_done   (o_result.done_res),
    .i_status (o_result.status),
    .i_level  (o_result.water_level)
);

`default_nettype wire
